FILE: rtl/core/pmce_pkg.sv
// ============================================================================
// pmce_pkg
// Shared constants, codes and types of the p-median cost evaluator.
// ============================================================================
package pmce_pkg;

  // Problem size and value widths
  localparam int SITES        = 12;
  localparam int DIST_WIDTH   = 16;
  localparam int DEMAND_WIDTH = 16;
  localparam int COST_WIDTH   = 36;
  localparam int PROD_WIDTH   = DIST_WIDTH + DEMAND_WIDTH;

  // Index and address widths
  localparam int SITE_W  = $clog2(SITES);
  localparam int DIST_AW = $clog2(SITES * SITES);
  localparam int DEM_AW  = $clog2(SITES);

  // Fixed field widths of a transaction
  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 4;
  localparam int LOAD_W      = 16;
  localparam int MASK_W      = 12;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Field positions in the input tdata
  localparam int SITE_LSB  = 0;
  localparam int POINT_LSB = SITE_LSB + INDEX_W;
  localparam int LOAD_LSB  = POINT_LSB + INDEX_W;
  localparam int MASK_LSB  = LOAD_LSB + LOAD_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DIST   = 2'd0,
    ACT_DEMAND = 2'd1,
    ACT_EVAL   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_RUN,
    EV_DRAIN,
    EV_DONE
  } eval_state_e;

  // Read requests from the evaluator to both stores
  typedef struct packed {
    logic               dist_re;
    logic [DIST_AW-1:0] dist_addr;
    logic               dem_re;
    logic [DEM_AW-1:0]  dem_addr;
  } rd_req_t;

  // Finished evaluation handed to the output register
  typedef struct packed {
    logic                  valid;
    logic [COST_WIDTH-1:0] cost;
    logic                  no_open;
  } eval_res_t;

endpackage

FILE: rtl/core/pmce_ram.sv
// ============================================================================
// pmce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module pmce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pmce_eval.sv
// ============================================================================
// pmce_eval
// Evaluation sequencer: sweeps the distance store point by point, keeps the
// nearest open distance, weights it by demand and accumulates the cost.
// ============================================================================
module pmce_eval
  import pmce_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [MASK_W-1:0]       open_mask_i,
  input  logic [DIST_WIDTH-1:0]   dist_rdata_i,
  input  logic [DEMAND_WIDTH-1:0] dem_rdata_i,
  input  logic                    res_ack_i,
  output rd_req_t                 rd_req_o,
  output logic                    busy_o,
  output eval_res_t               res_o
);

  eval_state_e state_q, state_d;

  // Sweep counters: site i inner, point j outer
  logic [SITE_W-1:0]  i_q, j_q;
  logic [DIST_AW-1:0] base_q;
  logic [MASK_W-1:0]  mask_q;
  logic               issue;
  logic               last_site, last_point;

  // Stage 1: distance data returns
  logic v1_q, open1_q, first1_q, last1_q, tail1_q;
  logic [DIST_WIDTH-1:0] best_q;
  logic                  found_q;
  logic                  cur_found, take;
  logic [DIST_WIDTH-1:0] cur_best, new_best;

  // Stage 2: nearest distance and weight
  logic                    v2_q, tail2_q;
  logic [DIST_WIDTH-1:0]   minv_q;
  logic [DEMAND_WIDTH-1:0] dem_q;

  // Stage 3: weighted term
  logic                  v3_q, tail3_q;
  logic [PROD_WIDTH-1:0] prod_q;

  // Accumulator
  logic [COST_WIDTH-1:0] sum_q;
  logic [COST_WIDTH:0]   sum_ext;
  logic                  no_open_q;

  assign issue      = (state_q == EV_RUN);
  assign last_site  = (i_q == SITE_W'(SITES - 1));
  assign last_point = (j_q == SITE_W'(SITES - 1));

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d            = state_q;
    rd_req_o.dist_re   = issue;
    rd_req_o.dist_addr = base_q + DIST_AW'(j_q);
    rd_req_o.dem_re    = issue;
    rd_req_o.dem_addr  = DEM_AW'(j_q);
    busy_o             = (state_q != EV_IDLE);
    res_o.valid        = (state_q == EV_DONE);
    res_o.cost         = sum_q;
    res_o.no_open      = no_open_q;
    case (state_q)
      EV_IDLE: begin
        if (start_i) begin
          state_d = (open_mask_i[SITES-1:0] == '0) ? EV_DONE : EV_RUN;
        end
      end
      EV_RUN: begin
        if (last_site && last_point) begin
          state_d = EV_DRAIN;
        end
      end
      EV_DRAIN: begin
        if (v3_q && tail3_q) begin
          state_d = EV_DONE;
        end
      end
      EV_DONE: begin
        if (res_ack_i) begin
          state_d = EV_IDLE;
        end
      end
      default: state_d = EV_IDLE;
    endcase
  end

  // Advance the sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      base_q <= '0;
    end else if (state_q == EV_IDLE) begin
      i_q    <= '0;
      j_q    <= '0;
      base_q <= '0;
    end else if (issue) begin
      if (last_site) begin
        i_q    <= '0;
        base_q <= '0;
        j_q    <= last_point ? '0 : j_q + SITE_W'(1);
      end else begin
        i_q    <= i_q + SITE_W'(1);
        base_q <= base_q + DIST_AW'(SITES);
      end
    end
  end

  // Capture the mask at start
  always_ff @(posedge clk_i) begin
    if (state_q == EV_IDLE && start_i) begin
      mask_q <= open_mask_i;
    end
  end

  // Pipeline valid and tail flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q && last1_q;
      v3_q <= v2_q;
    end
  end

  // Tag each read with its place in the sweep
  always_ff @(posedge clk_i) begin
    open1_q  <= mask_q[i_q];
    first1_q <= (i_q == '0);
    last1_q  <= last_site;
    tail1_q  <= last_site && last_point;
  end

  // Running minimum over open sites of the current point
  assign cur_found = first1_q ? 1'b0 : found_q;
  assign cur_best  = best_q;
  assign take      = open1_q && (!cur_found || (dist_rdata_i <= cur_best));
  assign new_best  = take ? dist_rdata_i : cur_best;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      best_q  <= new_best;
      found_q <= cur_found || open1_q;
    end
    if (v1_q && last1_q) begin
      minv_q  <= new_best;
      dem_q   <= dem_rdata_i;
      tail2_q <= tail1_q;
    end
    if (v2_q) begin
      prod_q  <= PROD_WIDTH'(minv_q) * PROD_WIDTH'(dem_q);
      tail3_q <= tail2_q;
    end
  end

  // Accumulate with saturation
  assign sum_ext = {1'b0, sum_q} + (COST_WIDTH + 1)'(prod_q);

  always_ff @(posedge clk_i) begin
    if (state_q == EV_IDLE && start_i) begin
      sum_q     <= '0;
      no_open_q <= (open_mask_i[SITES-1:0] == '0);
    end else if (v3_q) begin
      sum_q <= sum_ext[COST_WIDTH] ? {COST_WIDTH{1'b1}} : sum_ext[COST_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/core/p_median_cost_eval_core.sv
// ============================================================================
// p_median_cost_eval_core
// P-median objective evaluator: loads a site-by-point distance store and a
// demand weight store, then returns the total weighted nearest-site cost.
// ============================================================================
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  s_axis  | in        | site_index, point_index, load_value,       | action
//          |           | open_mask, zero pad to 40 bits             |
//  m_axis  | out       | total_cost, zero pad to 40 bits            | no_open_site
//
//  A load transaction is written in the cycle it is accepted.
//  An evaluate holds s_axis_tready low while it sweeps every site-point pair,
//  as set by the single read port of the distance memory; an empty mask skips
//  the sweep but still holds it low. A stalled m_axis result lets the next evaluate
//  run, which then keeps s_axis_tready low until the output register drains.
//  Reset clears control state only; both stores are undefined until written.
//
module p_median_cost_eval_core
  import pmce_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // site_index[3:0], point_index[7:4], load_value[23:8], open_mask[35:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]    s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // total_cost[35:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // no_open_site[0]
  output logic                   m_axis_tuser
);

  logic                    s_accept;
  logic [INDEX_W-1:0]      site_idx, point_idx;
  logic [LOAD_W-1:0]       load_val;
  logic [MASK_W-1:0]       open_mask;
  logic                    dist_we, dem_we, start;
  logic [DIST_AW-1:0]      dist_waddr;
  logic [DIST_WIDTH-1:0]   dist_rdata;
  logic [DEMAND_WIDTH-1:0] dem_rdata;
  rd_req_t                 rd_req;
  eval_res_t               res;
  logic                    busy, res_load;

  logic                  out_valid_q;
  logic [COST_WIDTH-1:0] out_cost_q;
  logic                  out_flag_q;

  // Unpack the transaction
  assign site_idx  = s_axis_tdata[SITE_LSB +: INDEX_W];
  assign point_idx = s_axis_tdata[POINT_LSB +: INDEX_W];
  assign load_val  = s_axis_tdata[LOAD_LSB +: LOAD_W];
  assign open_mask = s_axis_tdata[MASK_LSB +: MASK_W];

  assign s_axis_tready = !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Decode the action; drop out-of-range writes and the unused code
  always_comb begin
    dist_we = 1'b0;
    dem_we  = 1'b0;
    start   = 1'b0;
    case (s_axis_tuser)
      ACT_DIST: begin
        dist_we = s_accept && (site_idx < INDEX_W'(SITES)) && (point_idx < INDEX_W'(SITES));
      end
      ACT_DEMAND: begin
        dem_we = s_accept && (point_idx < INDEX_W'(SITES));
      end
      ACT_EVAL: begin
        start = s_accept;
      end
      default: begin
        dist_we = 1'b0;
      end
    endcase
  end

  assign dist_waddr = DIST_AW'(site_idx) * DIST_AW'(SITES) + DIST_AW'(point_idx);

  // Distance store
  pmce_ram #(
    .WIDTH (DIST_WIDTH),
    .DEPTH (SITES * SITES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (load_val[DIST_WIDTH-1:0]),
    .re_i    (rd_req.dist_re),
    .raddr_i (rd_req.dist_addr),
    .rdata_o (dist_rdata)
  );

  // Demand weight store
  pmce_ram #(
    .WIDTH (DEMAND_WIDTH),
    .DEPTH (SITES)
  ) u_dem_ram (
    .clk_i   (clk_i),
    .we_i    (dem_we),
    .waddr_i (DEM_AW'(point_idx)),
    .wdata_i (load_val[DEMAND_WIDTH-1:0]),
    .re_i    (rd_req.dem_re),
    .raddr_i (rd_req.dem_addr),
    .rdata_o (dem_rdata)
  );

  // Evaluation sequencer
  pmce_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .open_mask_i  (open_mask),
    .dist_rdata_i (dist_rdata),
    .dem_rdata_i  (dem_rdata),
    .res_ack_i    (res_load),
    .rd_req_o     (rd_req),
    .busy_o       (busy),
    .res_o        (res)
  );

  // Output register: load when empty or being drained
  assign res_load = res.valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_cost_q <= res.cost;
      out_flag_q <= res.no_open;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_cost_q);
  assign m_axis_tuser  = out_flag_q;

  // An empty-mask result carries zero cost
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[COST_WIDTH-1:0] == '0)
    else $error("empty-mask result with nonzero cost");

  // An evaluate transaction closes the input side on the next cycle
  a_eval_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input accepted during evaluation");

  // Loads never coincide with the distance sweep
  a_no_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dist_we && rd_req.dist_re) && !(dem_we && rd_req.dem_re))
    else $error("store written while being swept");

  // A result is never overwritten while it waits
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_cost_q))
    else $error("pending result lost");

endmodule
